>>> design/sli_pkg.sv
// Package: shared types and codes for the sorted list block.
package sli_pkg;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_DELETE = 2'd1,
    MODE_LIST   = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_BADPOS = 2'd2,
    STAT_EMPTY  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_INSERT,
    S_DELETE,
    S_LIST
  } state_t;

endpackage

>>> design/sorted_list_insert_delete.sv
// Sorted list of signed 32-bit values with insert, positional delete and listing.
//
// Issue a word by raising start while busy is low. The list is kept in ascending order
// in one memory with one read port and one write port, and while busy every cycle
// moves one entry through that memory. An insert shifts up the entries greater than or
// equal to the new value, and finishes without raising busy when the list is empty or
// full. A delete closes the gap, and finishes without raising busy for the tail entry
// or a bad position. A listing gives one result per entry on consecutive cycles, with
// last on the final one. An empty listing, a refused word and mode 3 also finish
// without raising busy. Each result shows on the result ports for one cycle with
// strobe high, in the cycle after it is produced; the receiver cannot hold results off.
module sorted_list_insert_delete #(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         mode,
  input  logic signed [31:0] value,
  input  logic [4:0]         position,
  output logic               strobe,
  output logic [1:0]         status,
  output logic signed [31:0] element,
  output logic [4:0]         element_index,
  output logic [4:0]         entry_count,
  output logic               last
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > 5) ? CW : 5;

  logic [31:0] mem [DEPTH];
  logic [31:0] rdata;

  sli_pkg::state_t state, state_next;
  logic [CW-1:0]   count, count_next;
  logic [AW-1:0]   idx, idx_next;
  logic            place0, place0_next;
  logic signed [31:0] value_r;

  logic            we;
  logic [AW-1:0]   waddr;
  logic [31:0]     wdata;

  logic            emit;
  sli_pkg::status_t st_n;
  logic [31:0]     el_n;
  logic [XW-1:0]   eidx_n;
  logic            last_n;

  logic            accept;
  logic [CW-1:0]   cnt_m1;
  logic [XW-1:0]   count_x, pos_x, cnt_next_x;
  logic            pos_ok, is_last, is_less;

  assign busy    = (state != sli_pkg::S_IDLE);
  assign accept  = start && !busy;
  assign cnt_m1  = count - CW'(1);
  assign count_x = XW'(count);
  assign pos_x   = XW'(position);
  assign pos_ok  = (pos_x != '0) && (pos_x <= count_x);
  assign is_last = (CW'(idx) == cnt_m1);
  assign is_less = ($signed(rdata) < value_r);
  assign cnt_next_x = XW'(count_next);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[idx_next];
  end

  always_comb begin
    state_next = state;
    case (state)
      sli_pkg::S_IDLE: begin
        if (accept) begin
          case (sli_pkg::mode_t'(mode))
            sli_pkg::MODE_INSERT: begin
              if (count != '0 && count != CW'(DEPTH)) begin
                state_next = sli_pkg::S_INSERT;
              end
            end
            sli_pkg::MODE_DELETE: begin
              if (pos_ok && pos_x != count_x) begin
                state_next = sli_pkg::S_DELETE;
              end
            end
            sli_pkg::MODE_LIST: begin
              if (count != '0) begin
                state_next = sli_pkg::S_LIST;
              end
            end
            default: state_next = sli_pkg::S_IDLE;
          endcase
        end
      end
      sli_pkg::S_INSERT: begin
        if (place0 || is_less) begin
          state_next = sli_pkg::S_IDLE;
        end
      end
      sli_pkg::S_DELETE: begin
        if (is_last) begin
          state_next = sli_pkg::S_IDLE;
        end
      end
      sli_pkg::S_LIST: begin
        if (is_last) begin
          state_next = sli_pkg::S_IDLE;
        end
      end
      default: state_next = sli_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    we          = 1'b0;
    waddr       = '0;
    wdata       = value_r;
    idx_next    = idx;
    place0_next = 1'b0;
    count_next  = count;
    emit        = 1'b0;
    st_n        = sli_pkg::STAT_OK;
    el_n        = '0;
    eidx_n      = '0;
    last_n      = 1'b1;
    case (state)
      sli_pkg::S_IDLE: begin
        if (accept) begin
          case (sli_pkg::mode_t'(mode))
            sli_pkg::MODE_INSERT: begin
              if (count == CW'(DEPTH)) begin
                emit = 1'b1;
                st_n = sli_pkg::STAT_FULL;
              end else if (count == '0) begin
                we         = 1'b1;
                waddr      = '0;
                wdata      = value;
                count_next = CW'(1);
                emit       = 1'b1;
              end else begin
                idx_next = cnt_m1[AW-1:0];
              end
            end
            sli_pkg::MODE_DELETE: begin
              if (!pos_ok) begin
                emit = 1'b1;
                st_n = sli_pkg::STAT_BADPOS;
              end else if (pos_x == count_x) begin
                count_next = cnt_m1;
                emit       = 1'b1;
              end else begin
                idx_next = pos_x[AW-1:0];
              end
            end
            sli_pkg::MODE_LIST: begin
              if (count == '0) begin
                emit = 1'b1;
                st_n = sli_pkg::STAT_EMPTY;
              end else begin
                idx_next = '0;
              end
            end
            default: emit = 1'b1;
          endcase
        end
      end
      sli_pkg::S_INSERT: begin
        we = 1'b1;
        if (place0) begin
          waddr      = '0;
          count_next = count + CW'(1);
          emit       = 1'b1;
        end else if (is_less) begin
          waddr      = idx + AW'(1);
          count_next = count + CW'(1);
          emit       = 1'b1;
        end else begin
          waddr       = idx + AW'(1);
          wdata       = rdata;
          place0_next = (idx == '0);
          idx_next    = idx - AW'(1);
        end
      end
      sli_pkg::S_DELETE: begin
        we       = 1'b1;
        waddr    = idx - AW'(1);
        wdata    = rdata;
        idx_next = idx + AW'(1);
        if (is_last) begin
          count_next = cnt_m1;
          emit       = 1'b1;
        end
      end
      sli_pkg::S_LIST: begin
        emit     = 1'b1;
        el_n     = rdata;
        eidx_n   = XW'(idx) + XW'(1);
        last_n   = is_last;
        idx_next = idx + AW'(1);
      end
      default: emit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= sli_pkg::S_IDLE;
      count  <= '0;
      place0 <= 1'b0;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      place0 <= place0_next;
      strobe <= emit;
    end
  end

  always_ff @(posedge clk) begin
    idx           <= idx_next;
    status        <= st_n;
    element       <= el_n;
    element_index <= eidx_n[4:0];
    entry_count   <= cnt_next_x[4:0];
    last          <= last_n;
    if (accept) begin
      value_r <= value;
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count beyond store depth");

  a_list_burst: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |=> strobe)
    else $error("listing burst broken");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    strobe && last |-> !busy)
    else $error("final word shown while still busy");

  a_full_refuse: assert property (@(posedge clk) disable iff (rst)
    accept && mode == sli_pkg::MODE_INSERT && count == CW'(DEPTH) |=> count == CW'(DEPTH))
    else $error("insert into full store changed count");
`endif

endmodule
